// File: rtl/core/integer_to_radix_ascii_defines.svh
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_defines
// assertion macros shared by the converter checks
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ITRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itra check failed");

// next-cycle implication, disabled while reset is low
`define ITRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itra check failed");

`endif

// File: rtl/core/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg
// types, constants and the digit encoder of the radix ascii converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itra_pkg;

    localparam logic [6:0] DIGIT_ZERO         = 7'd48;
    localparam logic [6:0] LETTER_LOWER_A     = 7'd97;
    localparam logic [6:0] CASE_OFFSET        = 7'd32;
    localparam logic [3:0] FIRST_LETTER_DIGIT = 4'd10;
    localparam logic [4:0] MIN_RADIX          = 5'd2;
    localparam logic [4:0] MAX_RADIX          = 5'd16;

    typedef struct packed {
        logic        func;
        logic [63:0] value;
        logic [4:0]  radix;
        logic        upper;
    } t_in_item;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       lead_minus;
        logic [6:0] char_count;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       done;
        logic       quo_nz;
        logic [3:0] rem;
    } t_div_status;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d, input logic up);
        logic [6:0] letter;
        begin
            letter = 7'(d - FIRST_LETTER_DIGIT) + LETTER_LOWER_A;
            if (d < FIRST_LETTER_DIGIT) begin
                return DIGIT_ZERO + 7'(d);
            end
            return up ? (letter - CASE_OFFSET) : letter;
        end
    endfunction

endpackage

// File: rtl/core/itra_ram.sv
// ----------------------------------------------------------------------------
// itra_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/itra_divider.sv
// ----------------------------------------------------------------------------
// itra_divider
// bit-serial restoring divider of a wide value by a radix of 2 to 16
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itra_divider #(
    parameter int WIDTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [WIDTH-1:0]          i_dividend,
    input  logic [4:0]                i_base,
    output itra_pkg::t_div_status     o_status,
    output logic [WIDTH-1:0]          o_quotient
);

    localparam int CNTW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNTW-1:0]  r_cnt;
    logic [WIDTH-1:0] r_shift;
    logic [3:0]       r_rem;
    logic [4:0]       r_base;
    logic             r_nz;

    logic [4:0] w_trial;
    logic       w_ge;
    logic [4:0] w_diff;

    // remainder shifted left with the next dividend bit, msb first
    assign w_trial = {r_rem, r_shift[WIDTH-1]};
    assign w_ge    = (w_trial >= r_base);
    assign w_diff  = w_trial - r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= CNTW'(WIDTH - 1);
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_base  <= i_base;
            r_nz    <= 1'b0;
        end else if (r_busy) begin
            r_cnt   <= r_cnt - CNTW'(1);
            r_shift <= {r_shift[WIDTH-2:0], w_ge};
            r_rem   <= w_ge ? w_diff[3:0] : w_trial[3:0];
            r_nz    <= r_nz | w_ge;
        end
    end

    assign o_status.done   = r_done;
    assign o_status.quo_nz = r_nz;
    assign o_status.rem    = r_rem;
    assign o_quotient      = r_shift;

endmodule

// File: rtl/core/integer_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// converts an integer into ascii digits of a radix from 2 to 16
// ----------------------------------------------------------------------------
// One request carries a value, a signed/unsigned selector, a radix and a
// letter-case flag; the block answers with one result per digit, most
// significant first, no leading zeros, a zero value giving the single digit
// '0'. A negative signed value converts its two's-complement magnitude, and
// its first result flags the '-' that precedes it. Every result carries the
// full character count and the final one is marked last. Radix 0 and 1 act
// as 2, radix above 16 acts as 16; value bits at and above VALUE_WIDTH are
// ignored. One request is converted at a time: each digit comes from a
// division in the bit-serial divider (one quotient bit per cycle), then
// the digits are read back from the ram, one cycle per result while the
// receiver does not stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_radix_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  itra_pkg::t_in_item  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output itra_pkg::t_out_item o_out_data
);

    // digit buffer address width and a count wide enough for sign + digits
    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 2);

    itra_pkg::t_state r_state, n_state;
    logic             r_neg,   n_neg;
    logic             r_up,    n_up;
    logic [4:0]       r_base,  n_base;
    logic [CW-1:0]    r_n,     n_n;   // digits stored so far
    logic [CW-1:0]    r_k,     n_k;   // index of the digit being shown

    // request decode
    logic [VALUE_WIDTH-1:0] w_v;
    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [4:0]             w_base;

    // divider hookup
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [4:0]             div_base;
    itra_pkg::t_div_status  div_st;
    logic [VALUE_WIDTH-1:0] div_quo;

    // digit buffer hookup
    logic          wr_en;
    logic          rd_en;
    logic [CW-1:0] rd_pos;
    logic [3:0]    rd_digit;
    logic          w_last;

    // only the low VALUE_WIDTH bits count; the sign bit is the top one of those
    assign w_v   = i_in_data.value[VALUE_WIDTH-1:0];
    assign w_neg = i_in_data.func & w_v[VALUE_WIDTH-1];
    // two's-complement negation taken as unsigned, so the most negative value works
    assign w_mag = w_neg ? (~w_v + VALUE_WIDTH'(1)) : w_v;

    // radix saturates to 2..16
    always_comb begin
        if (i_in_data.radix < itra_pkg::MIN_RADIX) begin
            w_base = itra_pkg::MIN_RADIX;
        end else if (i_in_data.radix > itra_pkg::MAX_RADIX) begin
            w_base = itra_pkg::MAX_RADIX;
        end else begin
            w_base = i_in_data.radix;
        end
    end

    // first request of an item takes the fresh radix, repeats reuse the held one
    assign div_base = (r_state == itra_pkg::ST_IDLE) ? w_base : r_base;

    itra_divider #(
        .WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_base     (div_base),
        .o_status   (div_st),
        .o_quotient (div_quo)
    );

    // digits land least significant first and are read back in reverse
    itra_ram #(
        .WIDTH (4),
        .DEPTH (VALUE_WIDTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_n[AW-1:0]),
        .i_wr_data (div_st.rem),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_pos[AW-1:0]),
        .o_rd_data (rd_digit)
    );

    assign rd_pos = r_n - CW'(1) - n_k;
    assign w_last = (r_k == (r_n - CW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itra_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_up   <= n_up;
        r_base <= n_base;
        r_n    <= n_n;
        r_k    <= n_k;
    end

    always_comb begin
        n_state      = r_state;
        n_neg        = r_neg;
        n_up         = r_up;
        n_base       = r_base;
        n_n          = r_n;
        n_k          = r_k;
        o_in_stall   = 1'b1;
        div_start    = 1'b0;
        div_dividend = w_mag;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (r_state)
            itra_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_neg     = w_neg;
                    n_up      = i_in_data.upper;
                    n_base    = w_base;
                    n_n       = '0;
                    div_start = 1'b1;
                    n_state   = itra_pkg::ST_DIV;
                end
            end
            itra_pkg::ST_DIV: begin
                // each finished division yields one digit; go on while the quotient is nonzero
                if (div_st.done) begin
                    wr_en = 1'b1;
                    n_n   = r_n + CW'(1);
                    if (div_st.quo_nz) begin
                        div_start    = 1'b1;
                        div_dividend = div_quo;
                    end else begin
                        n_k     = '0;
                        n_state = itra_pkg::ST_READ;
                    end
                end
            end
            itra_pkg::ST_READ: begin
                // fetch the most significant digit
                rd_en   = 1'b1;
                n_state = itra_pkg::ST_OUT;
            end
            itra_pkg::ST_OUT: begin
                // on a taken result fetch the next digit right away
                if (!i_out_stall) begin
                    if (w_last) begin
                        n_state = itra_pkg::ST_IDLE;
                    end else begin
                        n_k   = r_k + CW'(1);
                        rd_en = 1'b1;
                    end
                end
            end
            default: begin
                n_state = itra_pkg::ST_IDLE;
            end
        endcase
    end

    // result held steady while stalled: no read and no index change then
    assign o_out_valid           = (r_state == itra_pkg::ST_OUT);
    assign o_out_data.digit_char = itra_pkg::digit_to_ascii(rd_digit, r_up);
    assign o_out_data.lead_minus = r_neg && (r_k == '0);
    assign o_out_data.char_count = 7'(r_n + CW'(r_neg));
    assign o_out_data.last       = w_last;

endmodule

// File: rtl/core/itra_checker.sv
// ----------------------------------------------------------------------------
// itra_checker
// port-level checks of the radix ascii converter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_to_radix_ascii_defines.svh"

module itra_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input itra_pkg::t_out_item o_out_data
);

    logic       w_minus_out;
    logic       w_more;
    logic       w_on;
    logic [6:0] w_count;

    assign w_minus_out = o_out_valid && o_out_data.lead_minus;
    assign w_more      = o_out_valid && !i_out_stall && !o_out_data.last;
    assign w_on        = o_out_valid && !o_out_data.lead_minus;
    assign w_count     = o_out_data.char_count;

    // a waiting result is not dropped
    `ITRA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // no new request is taken while results of the current one are out
    `ITRA_ASSERT_NOW(a_one_item, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // a minus sign leaves room for at least one digit
    `ITRA_ASSERT_NOW(a_minus_count, i_clk, i_rst_n, w_minus_out, w_count >= 7'd2)

    // a run continues with the same count and no further minus flag
    `ITRA_ASSERT_NEXT(a_run_steady, i_clk, i_rst_n, w_more, w_on && $stable(w_count))

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
